// ===== src/xfq_pkg.sv =====
// Shared types and constants for the xor filter membership query block.
// Used by xfq_hash, xfq_table and xor_filter_membership_query_top.
`default_nettype none

package xfq_pkg;

    localparam int KEY_W  = 64;
    localparam int SEED_W = 32;
    localparam int BL_W   = 11;
    localparam int IDX_W  = 12;
    localparam int FP_W   = 8;
    localparam int CFG_W  = 32;
    localparam int CFG_IDX_W = 1;

    localparam int TABLE_DEPTH_DEF = 4096;

    // Multipliers of the 64-bit finalizer.
    localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_HASH_SEED    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = 1'b1;

    // Request kinds.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Control and write payload that travels with each beat down the pipe.
    typedef struct packed {
        logic             vld;
        logic             query;
        logic [IDX_W-1:0] idx;
        logic [FP_W-1:0]  val;
    } xfq_lane_t;

endpackage

`default_nettype wire

// ===== src/xfq_hash.sv =====
// Six-stage hash pipeline: seed add, split 64-bit finalizer, slot scaling.
// Depends on xfq_pkg for widths, multiplier constants and the lane type.
`default_nettype none

module xfq_hash
    import xfq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire xfq_lane_t         lane_in,
    input  wire logic [KEY_W-1:0]  key,
    input  wire logic [SEED_W-1:0] seed,
    input  wire logic [BL_W-1:0]   blen,
    output xfq_lane_t              lane_out,
    output logic [FP_W-1:0]        fp,
    output logic [BL_W-1:0]        slot0,
    output logic [BL_W-1:0]        slot1,
    output logic [BL_W-1:0]        slot2
);

    xfq_lane_t   lane1_reg, lane2_reg, lane3_reg, lane4_reg, lane5_reg, lane6_reg;
    logic [63:0] sum_reg;
    logic [63:0] p0_reg, y_reg, q0_reg, h_reg;
    logic [31:0] p1_reg, p2_reg, q1_reg, q2_reg;
    logic [FP_W-1:0] fp_reg;
    logic [BL_W-1:0] slot0_reg, slot1_reg, slot2_reg;

    logic [63:0] x, z, w;
    logic [31:0] pt1, pt2, qt1, qt2;
    logic [42:0] sa, sb, sc;

    // The 64x64 low product is split into one full 32x32 product and two
    // cross terms of which only the low halves matter.
    always_comb
    begin
        x   = sum_reg ^ (sum_reg >> 30);
        pt1 = x[63:32] * MIX_C1[31:0];
        pt2 = x[31:0] * MIX_C1[63:32];
        z   = y_reg ^ (y_reg >> 27);
        qt1 = z[63:32] * MIX_C2[31:0];
        qt2 = z[31:0] * MIX_C2[63:32];
        w   = q0_reg + {q1_reg + q2_reg, 32'b0};
        sa  = 43'(h_reg[31:0]) * 43'(blen);
        sb  = 43'(h_reg[47:16]) * 43'(blen);
        sc  = 43'(h_reg[63:32]) * 43'(blen);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane1_reg <= '0;
            lane2_reg <= '0;
            lane3_reg <= '0;
            lane4_reg <= '0;
            lane5_reg <= '0;
            lane6_reg <= '0;
        end
        else if (adv)
        begin
            lane1_reg <= lane_in;
            lane2_reg <= lane1_reg;
            lane3_reg <= lane2_reg;
            lane4_reg <= lane3_reg;
            lane5_reg <= lane4_reg;
            lane6_reg <= lane5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum_reg   <= key + {32'b0, seed};
            p0_reg    <= 64'(x[31:0]) * 64'(MIX_C1[31:0]);
            p1_reg    <= pt1;
            p2_reg    <= pt2;
            y_reg     <= p0_reg + {p1_reg + p2_reg, 32'b0};
            q0_reg    <= 64'(z[31:0]) * 64'(MIX_C2[31:0]);
            q1_reg    <= qt1;
            q2_reg    <= qt2;
            h_reg     <= w ^ (w >> 31);
            fp_reg    <= h_reg[FP_W-1:0];
            slot0_reg <= sa[42:32];
            slot1_reg <= sb[42:32];
            slot2_reg <= sc[42:32];
        end
    end

    assign lane_out = lane6_reg;
    assign fp       = fp_reg;
    assign slot0    = slot0_reg;
    assign slot1    = slot1_reg;
    assign slot2    = slot2_reg;

endmodule

`default_nettype wire

// ===== src/xfq_table.sv =====
// Fingerprint table: three copies written together, each read at one address.
// Depends on xfq_pkg for the fingerprint width.
`default_nettype none

module xfq_table
    import xfq_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           wr_en,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
    input  wire logic [FP_W-1:0]                wr_data,
    input  wire logic                           rd_en,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0] rd_addr0,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0] rd_addr1,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0] rd_addr2,
    output logic [FP_W-1:0]                     rd_data0,
    output logic [FP_W-1:0]                     rd_data1,
    output logic [FP_W-1:0]                     rd_data2
);

    logic [FP_W-1:0] mem0 [TABLE_DEPTH];
    logic [FP_W-1:0] mem1 [TABLE_DEPTH];
    logic [FP_W-1:0] mem2 [TABLE_DEPTH];
    logic [FP_W-1:0] rd0_reg, rd1_reg, rd2_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem0[wr_addr] <= wr_data;
            mem1[wr_addr] <= wr_data;
            mem2[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd0_reg <= mem0[rd_addr0];
            rd1_reg <= mem1[rd_addr1];
            rd2_reg <= mem2[rd_addr2];
        end
    end

    assign rd_data0 = rd0_reg;
    assign rd_data1 = rd1_reg;
    assign rd_data2 = rd2_reg;

endmodule

`default_nettype wire

// ===== src/xor_filter_membership_query_top.sv =====
// Xor filter membership query: a request channel carries table writes and key
// queries; a result channel returns one may_contain bit per query beat.
// Write beats fill one fingerprint entry and return nothing. A query beat
// adds hash_seed to lookup_key, mixes the sum and reads one entry from each
// third of the table; the XOR of the three entries and the low hash byte is
// zero when the key may be a member.
// Throughput is one beat per cycle while res_ready does not hold the pipe. A
// query's result passes six hash stages, a table read stage and the result
// register. Writes land at the table read stage, in order with queries, so a
// query sees every write accepted ahead of it. When the receiver holds res_ready
// low with a result waiting, the whole pipe freezes and req_ready drops; nothing
// is lost or repeated. Reset clears all beat valids and sets hash_seed to 0 and
// block_length to 1; table contents are undefined until written.
// Configuration writes through cfg_we take effect at once; the user must make
// them only while the pipe is empty, and the block itself does not enforce it.
`default_nettype none

module xor_filter_membership_query_top
    import xfq_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 req_valid,
    output logic                      req_ready,
    input  wire logic                 req_type,
    input  wire logic [IDX_W-1:0]     entry_index,
    input  wire logic [FP_W-1:0]      entry_value,
    input  wire logic [KEY_W-1:0]     lookup_key,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output logic                      may_contain
);

    localparam int          AW      = $clog2(TABLE_DEPTH);
    localparam logic [31:0] DEPTH_L = 32'(TABLE_DEPTH);

    logic [SEED_W-1:0] seed_reg;
    logic [BL_W-1:0]   blen_reg;

    logic      adv;
    xfq_lane_t lane_in, lane6;
    logic [FP_W-1:0] fp6;
    logic [BL_W-1:0] slot0, slot1, slot2;

    logic [31:0] addr0, addr1, addr2, waddr;
    logic [2:0]  ok_next;
    logic        wr_en;

    logic [FP_W-1:0] rd0, rd1, rd2;
    logic            m_vld_reg, m_query_reg;
    logic [FP_W-1:0] m_fp_reg;
    logic [2:0]      m_ok_reg;
    logic [FP_W-1:0] fold;
    logic            may_contain_next;
    logic            res_valid_reg, may_contain_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
            blen_reg <= BL_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HASH_SEED:    seed_reg <= cfg_data[SEED_W-1:0];
                REG_BLOCK_LENGTH: blen_reg <= cfg_data[BL_W-1:0];
                default:          ;
            endcase
        end
    end

    assign adv       = !res_valid_reg || res_ready;
    assign req_ready = adv;

    always_comb
    begin
        lane_in.vld   = req_valid;
        lane_in.query = (req_type == REQ_QUERY);
        lane_in.idx   = entry_index;
        lane_in.val   = entry_value;
    end

    xfq_hash u_hash (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .lane_in  (lane_in),
        .key      (lookup_key),
        .seed     (seed_reg),
        .blen     (blen_reg),
        .lane_out (lane6),
        .fp       (fp6),
        .slot0    (slot0),
        .slot1    (slot1),
        .slot2    (slot2)
    );

    // Offsets into the second and third thirds; indexes past the table read
    // as zero, and write indexes past it are dropped.
    always_comb
    begin
        addr0      = 32'(slot0);
        addr1      = 32'(slot1) + 32'(blen_reg);
        addr2      = 32'(slot2) + (32'(blen_reg) << 1);
        waddr      = 32'(lane6.idx);
        ok_next[0] = addr0 < DEPTH_L;
        ok_next[1] = addr1 < DEPTH_L;
        ok_next[2] = addr2 < DEPTH_L;
        wr_en      = adv && lane6.vld && !lane6.query && (waddr < DEPTH_L);
    end

    xfq_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (waddr[AW-1:0]),
        .wr_data  (lane6.val),
        .rd_en    (adv),
        .rd_addr0 (addr0[AW-1:0]),
        .rd_addr1 (addr1[AW-1:0]),
        .rd_addr2 (addr2[AW-1:0]),
        .rd_data0 (rd0),
        .rd_data1 (rd1),
        .rd_data2 (rd2)
    );

    // Table read stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg   <= 1'b0;
            m_query_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_vld_reg   <= lane6.vld;
            m_query_reg <= lane6.query;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_fp_reg <= fp6;
            m_ok_reg <= ok_next;
        end
    end

    always_comb
    begin
        fold = m_fp_reg
             ^ (m_ok_reg[0] ? rd0 : '0)
             ^ (m_ok_reg[1] ? rd1 : '0)
             ^ (m_ok_reg[2] ? rd2 : '0);
        may_contain_next = (fold == '0);
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            res_valid_reg <= m_vld_reg && m_query_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            may_contain_reg <= may_contain_next;
        end
    end

    assign res_valid   = res_valid_reg;
    assign may_contain = may_contain_reg;

`ifndef SYNTHESIS
    a_stall_holds_read_stage: assert property (
        @(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(m_vld_reg) && $stable(m_query_reg) && $stable(m_fp_reg)
    ) else $error("read stage changed during a stall");

    a_result_from_query: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(m_vld_reg && m_query_reg)
    ) else $error("result appeared without a query beat");

    a_write_gives_no_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (adv && m_vld_reg && !m_query_reg) |=> !res_valid_reg
    ) else $error("write beat produced a result");
`endif

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for xor_filter_membership_query_top: table writes and
// key queries go in over a valid/ready channel, and each query's may_contain bit is
// checked against a predictor kept in this file. Depends on xfq_pkg.
`timescale 1ns / 1ps

module tb;
    import xfq_pkg::*;

    localparam int DEPTH = 4096;

    typedef struct {
        logic             kind;
        logic [IDX_W-1:0] idx;
        logic [FP_W-1:0]  val;
        logic [KEY_W-1:0] key;
        bit               hold;
    } req_beat_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    logic                 req_type = REQ_WRITE;
    logic [IDX_W-1:0]     entry_index = '0;
    logic [FP_W-1:0]      entry_value = '0;
    logic [KEY_W-1:0]     lookup_key = '0;
    logic                 res_valid;
    logic                 res_ready = 1'b0;
    logic                 may_contain;

    xor_filter_membership_query_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_type    (req_type),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .lookup_key  (lookup_key),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .may_contain (may_contain)
    );

    // Predictor state, advanced as beats are accepted.
    logic [SEED_W-1:0] cur_seed = '0;
    logic [BL_W-1:0]   cur_blen = 11'd1;
    logic [FP_W-1:0]   fp_store [DEPTH];
    bit                hit_q [$];

    // Planning state, advanced as beats are queued; it runs ahead of the DUT.
    logic [FP_W-1:0]   plan_fp [DEPTH];
    bit                plan_written [DEPTH];
    req_beat_t         beat_q [$];

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    bit          req_taken = 0;
    int          errors = 0;
    int          writes_seen = 0;
    int          queries_seen = 0;
    int          members_seen = 0;
    int          queued_beats = 0;

    function automatic logic [63:0] mix_key(input logic [63:0] key, input logic [31:0] seed);
        logic [63:0] v;
        v = key + {32'b0, seed};
        v = (v ^ (v >> 30)) * 64'hbf58_476d_1ce4_e5b9;
        v = (v ^ (v >> 27)) * 64'h94d0_49bb_1331_11eb;
        return v ^ (v >> 31);
    endfunction

    function automatic logic [31:0] reduce_slice(input logic [31:0] s, input logic [10:0] n);
        logic [63:0] p;
        p = {32'b0, s} * {53'b0, n};
        return p[63:32];
    endfunction

    // Fingerprint byte and the one slot per table third that a key probes.
    task automatic probe_slots(input logic [63:0] key, output logic [7:0] fp,
                               output logic [31:0] sa, output logic [31:0] sb,
                               output logic [31:0] sc);
        logic [63:0] h;
        h  = mix_key(key, cur_seed);
        fp = h[7:0];
        sa = reduce_slice(h[31:0], cur_blen);
        sb = reduce_slice(h[47:16], cur_blen) + {21'b0, cur_blen};
        sc = reduce_slice(h[63:32], cur_blen) + {20'b0, cur_blen, 1'b0};
    endtask

    function automatic logic [7:0] stored_fp(input logic [31:0] i);
        return (i < DEPTH) ? fp_store[i] : 8'h00;
    endfunction

    function automatic logic [7:0] planned_fp(input logic [31:0] i);
        return (i < DEPTH) ? plan_fp[i] : 8'h00;
    endfunction

    task automatic queue_write(input logic [IDX_W-1:0] idx, input logic [FP_W-1:0] val);
        req_beat_t b;
        b = '{REQ_WRITE, idx, val, {$urandom, $urandom}, 1'b0};
        plan_fp[idx] = val;
        plan_written[idx] = 1'b1;
        beat_q.push_back(b);
        queued_beats++;
    endtask

    // Fills any slot the key would read that is still unwritten, optionally plants
    // a fingerprint so the key hits, then queues the query itself.
    task automatic queue_query(input logic [63:0] key, input bit make_hit, input bit hold);
        logic [7:0]  fp;
        logic [31:0] s [3];
        req_beat_t   b;
        probe_slots(key, fp, s[0], s[1], s[2]);
        for (int k = 0; k < 3; k++)
        begin
            if (s[k] < DEPTH && !plan_written[s[k]])
                queue_write(s[k][IDX_W-1:0], FP_W'($urandom_range(255)));
        end
        if (make_hit)
        begin
            // With a zero block length all three probes land on entry 0.
            if (cur_blen == 0)
                queue_write('0, fp);
            else
                queue_write(s[0][IDX_W-1:0], fp ^ planned_fp(s[1]) ^ planned_fp(s[2]));
        end
        b = '{REQ_QUERY, IDX_W'($urandom), FP_W'($urandom), key, hold};
        beat_q.push_back(b);
        queued_beats++;
    endtask

    function automatic logic [63:0] pick_key();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8)
            return 64'hffff_ffff_ffff_ffff - 64'($urandom_range(3));
        else if (r < 12)
            return 64'($urandom_range(3));
        return {$urandom, $urandom};
    endfunction

    task automatic wait_drained();
        while (beat_q.size() != 0 || req_valid || hit_q.size() != 0)
            @(posedge clk);
        // Writes give no result and may still be in the pipe.
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_HASH_SEED)
            cur_seed = data[SEED_W-1:0];
        else
            cur_blen = data[BL_W-1:0];
    endtask

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(negedge clk)
    begin : drive_req
        req_beat_t nxt;
        if (rst_n)
        begin
            if (!req_valid || req_taken)
            begin
                req_taken = 0;
                if (beat_q.size() != 0 && !(beat_q[0].hold && hit_q.size() != 0)
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = beat_q.pop_front();
                    req_type    <= nxt.kind;
                    entry_index <= nxt.idx;
                    entry_value <= nxt.val;
                    lookup_key  <= nxt.key;
                    req_valid   <= 1'b1;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
            res_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin : watch
        logic [7:0]  fp;
        logic [31:0] sa, sb, sc;
        bit          want;
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                req_taken = 1;
                if (req_type == REQ_WRITE)
                begin
                    fp_store[entry_index] = entry_value;
                    writes_seen++;
                end
                else
                begin
                    probe_slots(lookup_key, fp, sa, sb, sc);
                    want = ((fp ^ stored_fp(sa) ^ stored_fp(sb) ^ stored_fp(sc)) == 8'h00);
                    hit_q.push_back(want);
                    queries_seen++;
                    if (want)
                        members_seen++;
                end
            end
            if (res_valid && res_ready)
            begin
                if (hit_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat, may_contain=%b", $time, may_contain);
                    errors++;
                end
                else
                begin
                    want = hit_q.pop_front();
                    if (may_contain !== want)
                    begin
                        $display("%0t: may_contain mismatch, expected %b, actual %b",
                                 $time, want, may_contain);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        logic [31:0] seed_val;
        logic [31:0] blen_val;
        int          start;
        foreach (plan_written[i])
        begin
            plan_written[i] = 1'b0;
            plan_fp[i] = 8'h00;
            fp_store[i] = 8'h00;
        end
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part under the reset settings: seed 0, one entry per third.
        queue_write(12'd0, 8'h00);
        queue_write(12'd1, 8'hff);
        queue_write(12'd2, 8'h5a);
        queue_write(12'hfff, 8'hff);
        queue_write(12'h800, 8'h80);
        queue_write(12'h555, 8'h01);
        queue_query(64'h0, 1'b0, 1'b0);
        queue_query(64'hffff_ffff_ffff_ffff, 1'b0, 1'b0);
        queue_query(64'h8000_0000_0000_0000, 1'b1, 1'b0);
        queue_query(64'h0123_4567_89ab_cdef, 1'b1, 1'b1);
        queue_query(64'hffff_ffff_ffff_ffff, 1'b1, 1'b0);
        queue_query(64'h7fff_ffff_ffff_ffff, 1'b0, 1'b1);
        wait_drained();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin seed_val = $urandom; blen_val = 32'd1365;
                         send_idle_pct = 0;  stall_pct = 0;  end
                1: begin seed_val = 32'hffff_ffff; blen_val = 32'd1;
                         send_idle_pct = 55; stall_pct = 0;  end
                // A zero block length sends every probe to entry 0.
                2: begin seed_val = $urandom; blen_val = 32'd0;
                         send_idle_pct = 0;  stall_pct = 55; end
                // All-ones data: block length 2047 pushes the third slot past the table.
                3: begin seed_val = $urandom; blen_val = 32'hffff_ffff;
                         send_idle_pct = 20; stall_pct = 20; end
                4: begin seed_val = 32'h0; blen_val = $urandom_range(2, 400);
                         send_idle_pct = 0;  stall_pct = 0;  end
                default: begin seed_val = $urandom; blen_val = $urandom_range(401, 1365);
                         send_idle_pct = 20; stall_pct = 20; end
            endcase
            write_reg(REG_HASH_SEED, seed_val);
            write_reg(REG_BLOCK_LENGTH, blen_val);
            start = queued_beats;
            while (queued_beats - start < 175)
            begin
                if ($urandom_range(99) < 12)
                    queue_write(IDX_W'($urandom), FP_W'($urandom));
                else
                    queue_query(pick_key(), $urandom_range(99) < 40, $urandom_range(199) == 0);
            end
            wait_drained();
        end

        $display("Ran %0d table writes and %0d queries (%0d possible members)",
                 writes_seen, queries_seen, members_seen);
        $display("over seven seed/block-length settings, including zero and out-of-table lengths.");
        if (errors == 0 && hit_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
